FILE: rtl/qcg_pkg.sv
// shared types and constants for the quad cell geometry unit
`default_nettype none
package qcg_pkg;

  localparam int AREA_W = 48;

  typedef enum logic [1:0] {
    KIND_CENTROID = 2'd0,
    KIND_NORMAL   = 2'd1,
    KIND_TAU1     = 2'd2,
    KIND_TAU2     = 2'd3
  } kind_t;

  typedef struct packed {
    logic degen;
    logic d1zero;
  } flags_t;

endpackage
`default_nettype wire

FILE: rtl/quad_cell_geometry_unit.sv
// top level of the quad cell geometry unit
// pipeline: 6 front stages, 2*COORD_WIDTH+3 root stages, FRAC_BITS+1 divide
// stages and 3 vector and output stages; results leave at one result a cycle
// cells overlap in the pipeline; busy rises after each transfer in and spaces
// the cells so that the four results of each share the one result port
// the receiver cannot stall; rst clears the valid bits, the busy counter and the sequencer only
`default_nettype none
module quad_cell_geometry_unit import qcg_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] v0_x,
  input  logic signed [COORD_WIDTH-1:0] v0_y,
  input  logic signed [COORD_WIDTH-1:0] v0_z,
  input  logic signed [COORD_WIDTH-1:0] v1_x,
  input  logic signed [COORD_WIDTH-1:0] v1_y,
  input  logic signed [COORD_WIDTH-1:0] v1_z,
  input  logic signed [COORD_WIDTH-1:0] v2_x,
  input  logic signed [COORD_WIDTH-1:0] v2_y,
  input  logic signed [COORD_WIDTH-1:0] v2_z,
  input  logic signed [COORD_WIDTH-1:0] v3_x,
  input  logic signed [COORD_WIDTH-1:0] v3_y,
  input  logic signed [COORD_WIDTH-1:0] v3_z,
  output logic                          strobe,
  output logic [1:0]                    vec_kind,
  output logic signed [COORD_WIDTH-1:0] comp_x,
  output logic signed [COORD_WIDTH-1:0] comp_y,
  output logic signed [COORD_WIDTH-1:0] comp_z,
  output logic [AREA_W-1:0]             cell_area,
  output logic                          degenerate,
  output logic                          last
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = W + 1;
  localparam int MW  = 2 * DW;
  localparam int SW  = 2 * MW + 2;
  localparam int RW  = SW / 2;
  localparam int NW  = MW + F + 1;
  localparam int QB  = F + 1;
  localparam int AXW = RW + AREA_W;
  localparam int SQS = 3 * MW + 3 * DW + 3 * W + 3 + 3 + 2;
  localparam int DVS = 3 * W + 3 + 3 + 2 + AREA_W;
  localparam logic [AXW-1:0] AMAX = (AXW'(1) << AREA_W) - AXW'(1);

  logic [1:0] gap;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else if (accept) begin
      gap <= 2'd3;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  logic signed [W-1:0] vtx [4][3];
  assign vtx[0][0] = v0_x;
  assign vtx[0][1] = v0_y;
  assign vtx[0][2] = v0_z;
  assign vtx[1][0] = v1_x;
  assign vtx[1][1] = v1_y;
  assign vtx[1][2] = v1_z;
  assign vtx[2][0] = v2_x;
  assign vtx[2][1] = v2_y;
  assign vtx[2][2] = v2_z;
  assign vtx[3][0] = v3_x;
  assign vtx[3][1] = v3_y;
  assign vtx[3][2] = v3_z;

  // front
  logic                fr_valid;
  logic [SW-1:0]       fr_csq, fr_dsq;
  logic [MW-1:0]       fr_cmag [3];
  logic [2:0]          fr_csign, fr_dsign;
  logic [DW-1:0]       fr_dmag [3];
  logic signed [W-1:0] fr_cent [3];
  flags_t              fr_flags;

  qcg_front #(.COORD_WIDTH(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .vtx       (vtx),
    .out_valid (fr_valid),
    .csq       (fr_csq),
    .dsq       (fr_dsq),
    .cmag      (fr_cmag),
    .csign     (fr_csign),
    .dmag      (fr_dmag),
    .dsign     (fr_dsign),
    .cent      (fr_cent),
    .flags     (fr_flags)
  );

  // roots
  logic [SW-1:0]       sq_rad [2];
  logic [SQS-1:0]      sq_side_in, sq_side_out;
  logic                sq_valid;
  logic [RW-1:0]       sq_root [2];
  logic [MW-1:0]       sq_cmag [3];
  logic [DW-1:0]       sq_dmag [3];
  logic signed [W-1:0] sq_cent [3];
  logic [2:0]          sq_csign, sq_dsign;
  flags_t              sq_flags;

  assign sq_rad[0] = fr_csq;
  assign sq_rad[1] = fr_dsq;
  assign sq_side_in = {fr_cmag[0], fr_cmag[1], fr_cmag[2], fr_dmag[0], fr_dmag[1],
                       fr_dmag[2], fr_cent[0], fr_cent[1], fr_cent[2], fr_csign,
                       fr_dsign, fr_flags};

  qcg_sqrt #(.RAD_W(SW), .SIDE_W(SQS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .rad       (sq_rad),
    .in_side   (sq_side_in),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side_out)
  );

  assign {sq_cmag[0], sq_cmag[1], sq_cmag[2], sq_dmag[0], sq_dmag[1], sq_dmag[2],
          sq_cent[0], sq_cent[1], sq_cent[2], sq_csign, sq_dsign, sq_flags} = sq_side_out;

  // area from the cross product norm
  logic [AXW-1:0]    area_sh;
  logic [AREA_W-1:0] area;

  assign area_sh = AXW'(sq_root[0]) >> (F + 1);
  assign area    = (area_sh > AMAX) ? AREA_W'(AMAX) : AREA_W'(area_sh);

  // unit vector quotients
  logic [NW-1:0]       dv_num [6];
  logic [RW-1:0]       dv_den [6];
  logic [DVS-1:0]      dv_side_in, dv_side_out;
  logic                dv_valid;
  logic [QB-1:0]       dv_quo [6];
  logic signed [W-1:0] dv_cent [3];
  logic [2:0]          dv_csign, dv_dsign;
  flags_t              dv_flags;
  logic [AREA_W-1:0]   dv_area;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_num[k]   = NW'(sq_cmag[k]) << F;
      dv_den[k]   = sq_root[0];
      dv_num[3+k] = NW'(sq_dmag[k]) << F;
      dv_den[3+k] = sq_root[1];
    end
  end

  assign dv_side_in = {sq_cent[0], sq_cent[1], sq_cent[2], sq_csign, sq_dsign,
                       sq_flags, area};

  qcg_div #(
    .LANES  (6),
    .NUM_W  (NW),
    .DEN_W  (RW),
    .QUO_W  (QB),
    .SIDE_W (DVS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .num       (dv_num),
    .den       (dv_den),
    .in_side   (dv_side_in),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_side  (dv_side_out)
  );

  assign {dv_cent[0], dv_cent[1], dv_cent[2], dv_csign, dv_dsign, dv_flags,
          dv_area} = dv_side_out;

  kind_t kind;

  qcg_emit #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dv_valid),
    .quo        (dv_quo),
    .csign      (dv_csign),
    .dsign      (dv_dsign),
    .cent       (dv_cent),
    .flags      (dv_flags),
    .area       (dv_area),
    .strobe     (strobe),
    .vec_kind   (kind),
    .comp_x     (comp_x),
    .comp_y     (comp_y),
    .comp_z     (comp_z),
    .cell_area  (cell_area),
    .degenerate (degenerate),
    .last       (last)
  );

  assign vec_kind = kind;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 busy ##1 busy)
    else $error("busy dropped within a cell slot");

  a_last_is_tau2: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> kind == KIND_TAU2)
    else $error("last flag on the wrong transfer");

  a_kind_order: assert property (@(posedge clk) disable iff (rst)
    strobe && kind != KIND_CENTROID |-> $past(strobe) && $stable(cell_area))
    else $error("result sequence broken");

  a_degen_normal_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && degenerate && (kind == KIND_NORMAL || kind == KIND_TAU2)
      |-> comp_x == '0 && comp_y == '0 && comp_z == '0)
    else $error("degenerate cell with nonzero normal");

endmodule
`default_nettype wire

FILE: rtl/qcg_front.sv
// front pipeline: diagonals, centroid, cross product and squared norms
`default_nettype none
module qcg_front import qcg_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] vtx [4][3],
  output logic                          out_valid,
  output logic [4*COORD_WIDTH+5:0]      csq,
  output logic [4*COORD_WIDTH+5:0]      dsq,
  output logic [2*COORD_WIDTH+1:0]      cmag [3],
  output logic [2:0]                    csign,
  output logic [COORD_WIDTH:0]          dmag [3],
  output logic [2:0]                    dsign,
  output logic signed [COORD_WIDTH-1:0] cent [3],
  output flags_t                        flags
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int MW = PW;
  localparam int HB = MW / 2;
  localparam int LW = MW - HB;
  localparam int SW = 2 * MW + 2;

  // stage 1
  logic                 v1;
  logic signed [DW-1:0] d1_1 [3];
  logic signed [DW-1:0] d2_1 [3];
  logic signed [W-1:0]  ce1 [3];
  // stage 2
  logic                 v2;
  logic signed [PW-1:0] pa2 [3];
  logic signed [PW-1:0] pb2 [3];
  logic [PW-1:0]        dq2 [3];
  logic signed [DW-1:0] d1_2 [3];
  logic signed [W-1:0]  ce2 [3];
  // stage 3
  logic                 v3;
  logic [MW-1:0]        cm3 [3];
  logic [2:0]           cs3;
  logic [SW-1:0]        ds3;
  logic [DW-1:0]        dm3 [3];
  logic [2:0]           dg3;
  logic signed [W-1:0]  ce3 [3];
  flags_t               fl3;
  // stage 4
  logic                 v4;
  logic [2*LW-1:0]      hh4 [3];
  logic [MW-1:0]        hl4 [3];
  logic [2*HB-1:0]      ll4 [3];
  logic [MW-1:0]        cm4 [3];
  logic [2:0]           cs4;
  logic [SW-1:0]        ds4;
  logic [DW-1:0]        dm4 [3];
  logic [2:0]           dg4;
  logic signed [W-1:0]  ce4 [3];
  flags_t               fl4;
  // stage 5
  logic                 v5;
  logic [SW-1:0]        sq5 [3];
  logic [MW-1:0]        cm5 [3];
  logic [2:0]           cs5;
  logic [SW-1:0]        ds5;
  logic [DW-1:0]        dm5 [3];
  logic [2:0]           dg5;
  logic signed [W-1:0]  ce5 [3];
  flags_t               fl5;

  logic signed [W+1:0]  csum [3];
  logic signed [PW:0]   cx [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csum[k] = (W+2)'(vtx[0][k]) + (W+2)'(vtx[1][k]) + (W+2)'(vtx[2][k])
              + (W+2)'(vtx[3][k]);
      cx[k]   = (PW+1)'(pa2[k]) - (PW+1)'(pb2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d1_1[k] <= DW'(vtx[0][k]) - DW'(vtx[2][k]);
      d2_1[k] <= DW'(vtx[1][k]) - DW'(vtx[3][k]);
      ce1[k]  <= W'(csum[k] >>> 2);
    end
    // cross terms of d1 x d2
    pa2[0] <= d1_1[1] * d2_1[2];
    pb2[0] <= d1_1[2] * d2_1[1];
    pa2[1] <= d1_1[2] * d2_1[0];
    pb2[1] <= d1_1[0] * d2_1[2];
    pa2[2] <= d1_1[0] * d2_1[1];
    pb2[2] <= d1_1[1] * d2_1[0];
    for (int k = 0; k < 3; k++) begin
      dq2[k]  <= PW'(d1_1[k] * d1_1[k]);
      d1_2[k] <= d1_1[k];
      ce2[k]  <= ce1[k];
    end
    for (int k = 0; k < 3; k++) begin
      cs3[k] <= cx[k][PW];
      cm3[k] <= cx[k][PW] ? MW'(-cx[k]) : MW'(cx[k]);
      dg3[k] <= d1_2[k][DW-1];
      dm3[k] <= d1_2[k][DW-1] ? DW'(-d1_2[k]) : DW'(d1_2[k]);
      ce3[k] <= ce2[k];
    end
    ds3 <= SW'(dq2[0]) + SW'(dq2[1]) + SW'(dq2[2]);
    fl3.degen  <= (cx[0] == '0) && (cx[1] == '0) && (cx[2] == '0);
    fl3.d1zero <= (d1_2[0] == '0) && (d1_2[1] == '0) && (d1_2[2] == '0);
    // split squares of |c| into half-width products
    for (int k = 0; k < 3; k++) begin
      hh4[k] <= cm3[k][MW-1:HB] * cm3[k][MW-1:HB];
      hl4[k] <= cm3[k][MW-1:HB] * cm3[k][HB-1:0];
      ll4[k] <= cm3[k][HB-1:0] * cm3[k][HB-1:0];
      cm4[k] <= cm3[k];
      dm4[k] <= dm3[k];
      ce4[k] <= ce3[k];
    end
    cs4 <= cs3;
    ds4 <= ds3;
    dg4 <= dg3;
    fl4 <= fl3;
    for (int k = 0; k < 3; k++) begin
      sq5[k] <= (SW'(hh4[k]) << (2 * HB)) + (SW'(hl4[k]) << (HB + 1)) + SW'(ll4[k]);
      cm5[k] <= cm4[k];
      dm5[k] <= dm4[k];
      ce5[k] <= ce4[k];
    end
    cs5 <= cs4;
    ds5 <= ds4;
    dg5 <= dg4;
    fl5 <= fl4;
    csq <= sq5[0] + sq5[1] + sq5[2];
    dsq <= ds5;
    for (int k = 0; k < 3; k++) begin
      cmag[k] <= cm5[k];
      dmag[k] <= dm5[k];
      cent[k] <= ce5[k];
    end
    csign <= cs5;
    dsign <= dg5;
    flags <= fl5;
  end

endmodule
`default_nettype wire

FILE: rtl/qcg_sqrt.sv
// pipelined integer square root, one root bit per stage, two lanes
`default_nettype none
module qcg_sqrt import qcg_pkg::*; #(
  parameter int RAD_W  = 136,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     rad [2],
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root [2],
  output logic [SIDE_W-1:0]    out_side
);

  localparam int RW = RAD_W / 2;

  logic              vld  [RW];
  logic [RAD_W-1:0]  rem  [RW][2];
  logic [RW-1:0]     rt   [RW][2];
  logic [SIDE_W-1:0] side [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int B = RW - 1 - s;
    logic              pv;
    logic [RAD_W-1:0]  prem [2];
    logic [RW-1:0]     prt  [2];
    logic [SIDE_W-1:0] pside;
    logic [RAD_W-1:0]  trial [2];

    if (s == 0) begin : g_first
      always_comb begin
        pv    = in_valid;
        pside = in_side;
        for (int l = 0; l < 2; l++) begin
          prem[l] = rad[l];
          prt[l]  = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        pv    = vld[s-1];
        pside = side[s-1];
        for (int l = 0; l < 2; l++) begin
          prem[l] = rem[s-1][l];
          prt[l]  = rt[s-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 2; l++)
        trial[l] = (RAD_W'(prt[l]) << (B + 1)) | (RAD_W'(1) << (2 * B));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      side[s] <= pside;
      for (int l = 0; l < 2; l++) begin
        if (prem[l] >= trial[l]) begin
          rem[s][l] <= prem[l] - trial[l];
          rt[s][l]  <= prt[l] | (RW'(1) << B);
        end else begin
          rem[s][l] <= prem[l];
          rt[s][l]  <= prt[l];
        end
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_side  = side[RW-1];
  assign root[0]   = rt[RW-1][0];
  assign root[1]   = rt[RW-1][1];

endmodule
`default_nettype wire

FILE: rtl/qcg_div.sv
// pipelined restoring divider, one quotient bit per stage, several lanes
`default_nettype none
module qcg_div import qcg_pkg::*; #(
  parameter int LANES  = 6,
  parameter int NUM_W  = 83,
  parameter int DEN_W  = 67,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num [LANES],
  input  logic [DEN_W-1:0]  den [LANES],
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo [LANES],
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [QUO_W];
  logic [NUM_W-1:0]  rem  [QUO_W][LANES];
  logic [DEN_W-1:0]  dv   [QUO_W][LANES];
  logic [QUO_W-1:0]  qq   [QUO_W][LANES];
  logic [SIDE_W-1:0] side [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - 1 - s;
    logic              pv;
    logic [NUM_W-1:0]  prem [LANES];
    logic [DEN_W-1:0]  pdv  [LANES];
    logic [QUO_W-1:0]  pq   [LANES];
    logic [SIDE_W-1:0] pside;
    logic [NUM_W-1:0]  trial [LANES];

    if (s == 0) begin : g_first
      always_comb begin
        pv    = in_valid;
        pside = in_side;
        for (int l = 0; l < LANES; l++) begin
          prem[l] = num[l];
          pdv[l]  = den[l];
          pq[l]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        pv    = vld[s-1];
        pside = side[s-1];
        for (int l = 0; l < LANES; l++) begin
          prem[l] = rem[s-1][l];
          pdv[l]  = dv[s-1][l];
          pq[l]   = qq[s-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++)
        trial[l] = NUM_W'(pdv[l]) << B;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      side[s] <= pside;
      for (int l = 0; l < LANES; l++) begin
        dv[s][l] <= pdv[l];
        if (prem[l] >= trial[l]) begin
          rem[s][l] <= prem[l] - trial[l];
          qq[s][l]  <= pq[l] | (QUO_W'(1) << B);
        end else begin
          rem[s][l] <= prem[l];
          qq[s][l]  <= pq[l];
        end
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_side  = side[QUO_W-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo[l] = qq[QUO_W-1][l];
  end

endmodule
`default_nettype wire

FILE: rtl/qcg_emit.sv
// unit vectors, second tangent and the four-result output sequencer
`default_nettype none
module qcg_emit import qcg_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [FRAC_BITS:0]            quo [6],
  input  logic [2:0]                    csign,
  input  logic [2:0]                    dsign,
  input  logic signed [COORD_WIDTH-1:0] cent [3],
  input  flags_t                        flags,
  input  logic [AREA_W-1:0]             area,
  output logic                          strobe,
  output kind_t                         vec_kind,
  output logic signed [COORD_WIDTH-1:0] comp_x,
  output logic signed [COORD_WIDTH-1:0] comp_y,
  output logic signed [COORD_WIDTH-1:0] comp_z,
  output logic [AREA_W-1:0]             cell_area,
  output logic                          degenerate,
  output logic                          last
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QB  = F + 1;
  localparam int EXW = W + QB;
  localparam int TW  = 2 * W + 1;
  localparam logic [EXW-1:0] QMAX = (EXW'(1) << (W - 1)) - EXW'(1);
  localparam logic [TW-1:0]  PMAX = (TW'(1) << (W - 1)) - TW'(1);

  logic                v1, v2;
  logic signed [W-1:0] nq1 [3];
  logic signed [W-1:0] tq1 [3];
  logic signed [W-1:0] ce1 [3];
  flags_t              fl1;
  logic [AREA_W-1:0]   ar1;
  logic signed [2*W-1:0] pa2 [3];
  logic signed [2*W-1:0] pb2 [3];
  logic signed [W-1:0] nq2 [3];
  logic signed [W-1:0] tq2 [3];
  logic signed [W-1:0] ce2 [3];
  flags_t              fl2;
  logic [AREA_W-1:0]   ar2;

  logic signed [W-1:0] hv [4][3];
  logic [AREA_W-1:0]   harea;
  logic                hdeg;

  logic [W-1:0]        mag_n [3];
  logic [W-1:0]        mag_t [3];
  logic signed [W-1:0] t2res [3];
  logic signed [TW-1:0] td;
  logic [TW-1:0]       tmag;
  logic [TW-1:0]       tsh;
  logic [TW-1:0]       tlim;
  logic [W-1:0]        tr;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_n[k] = (EXW'(quo[k]) > QMAX) ? W'(QMAX) : W'(quo[k]);
      mag_t[k] = (EXW'(quo[3+k]) > QMAX) ? W'(QMAX) : W'(quo[3+k]);
    end
  end

  always_comb begin
    td   = '0;
    tmag = '0;
    tsh  = '0;
    tlim = '0;
    tr   = '0;
    for (int k = 0; k < 3; k++) begin
      td   = TW'(pa2[k]) - TW'(pb2[k]);
      tmag = td[TW-1] ? TW'(-td) : TW'(td);
      tsh  = tmag >> F;
      tlim = td[TW-1] ? PMAX + TW'(1) : PMAX;
      tr   = (tsh > tlim) ? W'(tlim) : W'(tsh);
      t2res[k] = td[TW-1] ? -$signed(tr) : $signed(tr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      nq1[k] <= flags.degen ? '0 : (csign[k] ? -$signed(mag_n[k]) : $signed(mag_n[k]));
      tq1[k] <= flags.d1zero ? '0 : (dsign[k] ? -$signed(mag_t[k]) : $signed(mag_t[k]));
      ce1[k] <= cent[k];
    end
    fl1 <= flags;
    ar1 <= area;
    // n x tau1
    pa2[0] <= nq1[1] * tq1[2];
    pb2[0] <= nq1[2] * tq1[1];
    pa2[1] <= nq1[2] * tq1[0];
    pb2[1] <= nq1[0] * tq1[2];
    pa2[2] <= nq1[0] * tq1[1];
    pb2[2] <= nq1[1] * tq1[0];
    for (int k = 0; k < 3; k++) begin
      nq2[k] <= nq1[k];
      tq2[k] <= tq1[k];
      ce2[k] <= ce1[k];
    end
    fl2 <= fl1;
    ar2 <= ar1;
    if (v2) begin
      for (int k = 0; k < 3; k++) begin
        hv[0][k] <= ce2[k];
        hv[1][k] <= nq2[k];
        hv[2][k] <= tq2[k];
        hv[3][k] <= t2res[k];
      end
      harea <= ar2;
      hdeg  <= fl2.degen;
    end
  end

  // result sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe   <= 1'b0;
      vec_kind <= KIND_CENTROID;
    end else if (v2) begin
      strobe   <= 1'b1;
      vec_kind <= KIND_CENTROID;
    end else if (strobe) begin
      if (vec_kind == KIND_TAU2) begin
        strobe <= 1'b0;
      end else begin
        vec_kind <= kind_t'(vec_kind + 2'd1);
      end
    end
  end

  assign comp_x     = hv[vec_kind][0];
  assign comp_y     = hv[vec_kind][1];
  assign comp_z     = hv[vec_kind][2];
  assign cell_area  = harea;
  assign degenerate = hdeg;
  assign last       = (vec_kind == KIND_TAU2);

endmodule
`default_nettype wire
